// File: design/alc_pkg.sv
// alc_pkg: shared types, widths, constants and helper functions for the lux converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package alc_pkg;

  localparam int unsigned CNT_W          = 16;
  localparam int unsigned CFG_W          = 3;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned LUX_W          = 26;
  localparam int unsigned COEF_FRAC_BITS = 16;
  localparam int unsigned OUT_FRAC_BITS  = 8;

  localparam int unsigned COEF_W = COEF_FRAC_BITS + 3;
  localparam int unsigned PROD_W = COEF_W + CNT_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned X_W    = SUM_W + OUT_FRAC_BITS + 1;
  localparam int unsigned Y_W    = X_W - COEF_FRAC_BITS;
  localparam int unsigned CELLS  = Y_W;

  localparam int unsigned GAIN_W = 7;
  localparam int unsigned DIV_W  = 9;
  localparam int unsigned CMP_W  = CNT_W + 8;

  localparam int unsigned RATIO_SCALE = 100;
  localparam int unsigned RATIO_T0    = 45;
  localparam int unsigned RATIO_T1    = 64;
  localparam int unsigned RATIO_T2    = 85;

  localparam logic [CFG_W-1:0] UNITS_MIN = CFG_W'(1);
  localparam logic [CFG_W-1:0] UNITS_MAX = CFG_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] GAIN_RST  = CFG_W'(0);
  localparam logic [CFG_W-1:0] UNITS_RST = CFG_W'(1);

  localparam longint unsigned LUX_MAX = (64'd1 << LUX_W) - 64'd1;

  // coefficients rounded half up to COEF_FRAC_BITS
  localparam longint unsigned CA_L = ((64'd17743 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned CB_L = ((64'd11059 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned CA_M = ((64'd42785 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned CB_M = ((64'd19548 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned CA_H = ((64'd5926 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned CB_H = ((64'd1185 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_MID  = 2'd1,
    REG_HIGH = 2'd2,
    REG_OUT  = 2'd3
  } alc_region_e;

  typedef enum logic [CFG_W-1:0] {
    GAIN_1X  = 3'd0,
    GAIN_2X  = 3'd1,
    GAIN_4X  = 3'd2,
    GAIN_8X  = 3'd3,
    GAIN_48X = 3'd4,
    GAIN_96X = 3'd5
  } alc_gain_e;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Y_W-1:0]   num;
    alc_region_e      region;
  } alc_cell_t;

  function automatic logic [GAIN_W-1:0] gain_mult(logic [CFG_W-1:0] code);
    logic [GAIN_W-1:0] g;
    unique case (code)
      GAIN_1X:  g = GAIN_W'(1);
      GAIN_2X:  g = GAIN_W'(2);
      GAIN_4X:  g = GAIN_W'(4);
      GAIN_8X:  g = GAIN_W'(8);
      GAIN_48X: g = GAIN_W'(48);
      default:  g = GAIN_W'(96);
    endcase
    return g;
  endfunction

  function automatic logic [CFG_W-1:0] units_eff(logic [CFG_W-1:0] code);
    logic [CFG_W-1:0] u;
    if (code < UNITS_MIN) begin
      u = UNITS_MIN;
    end else if (code > UNITS_MAX) begin
      u = UNITS_MAX;
    end else begin
      u = code;
    end
    return u;
  endfunction

endpackage

// File: design/als_lux_converter.sv
// als_lux_converter: top level, config registers, front stages, divider cell chain, output register
// depends on alc_pkg, alc_front, alc_cell
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   visible_ir_count_i, ir_count_i
//   out      result     out_valid_o / out_stall_i lux_q8_o, region_o
//   cfg      write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one request per cycle sustained while out_stall_i is low; 4 front stages, 29 divider
// cells at one quotient bit each, 1 output register
// reset clears all stage valid bits and sets gain 1x, one integration unit
// each stage advances when the next one has room; in_stall_o rises only when
// every stage holds a request and out_stall_i is high
`timescale 1ns / 1ps

module als_lux_converter
  import alc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CNT_W-1:0]     visible_ir_count_i,
  input  logic [CNT_W-1:0]     ir_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LUX_W-1:0]     lux_q8_o,
  output logic [1:0]           region_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned SAT_W = Y_W + LUX_W;

  logic [CFG_W-1:0] gain_q, units_q;
  logic [GAIN_W+CFG_W-1:0] div_prod;
  logic [DIV_W-1:0] divisor;

  logic              fr_ready, fr_valid;
  logic [Y_W-1:0]    fr_y;
  alc_region_e       fr_region;

  logic      cv   [CELLS+1];
  logic      cr   [CELLS+1];
  alc_cell_t cd   [CELLS+1];

  logic              out_valid_q, out_ready;
  logic [LUX_W-1:0]  lux_q, lux_d;
  alc_region_e       region_q;
  logic [Y_W-1:0]    quot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RST;
      units_q <= UNITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GAIN:  gain_q  <= cfg_data_i;
        CFG_UNITS: units_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    div_prod = (GAIN_W + CFG_W)'(gain_mult(gain_q)) * (GAIN_W + CFG_W)'(units_eff(units_q));
    divisor  = div_prod[DIV_W-1:0];
  end

  alc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .divisor_i  (divisor),
    .up_valid_i (in_valid_i),
    .up_ready_o (fr_ready),
    .c0_i       (visible_ir_count_i),
    .c1_i       (ir_count_i),
    .dn_valid_o (fr_valid),
    .dn_ready_i (cr[0]),
    .y_o        (fr_y),
    .region_o   (fr_region)
  );

  assign in_stall_o = !fr_ready;

  always_comb begin
    cv[0]        = fr_valid;
    cd[0].rem    = '0;
    cd[0].num    = fr_y;
    cd[0].region = fr_region;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    alc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .divisor_i  (divisor),
      .up_valid_i (cv[i]),
      .up_ready_o (cr[i]),
      .up_data_i  (cd[i]),
      .dn_valid_o (cv[i+1]),
      .dn_ready_i (cr[i+1]),
      .dn_data_o  (cd[i+1])
    );
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign cr[CELLS]  = out_ready;

  always_comb begin
    quot = cd[CELLS].num;
    if (cd[CELLS].region == REG_OUT) begin
      lux_d = '0;
    end else if (SAT_W'(quot) > SAT_W'(LUX_MAX)) begin
      lux_d = LUX_W'(LUX_MAX);
    end else begin
      lux_d = LUX_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= cv[CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && cv[CELLS]) begin
      lux_q    <= lux_d;
      region_q <= cd[CELLS].region;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lux_q8_o    = lux_q;
  assign region_o    = region_q;

`ifndef SYNTH
  a_out_region_no_lux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && region_o == REG_OUT) |-> (lux_q8_o == '0))
    else $error("out-of-range region with nonzero lux");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (divisor != '0) && (divisor <= DIV_W'(384)))
    else $error("gain times integration outside its range");
`endif

endmodule

// File: design/alc_front.sv
// alc_front: ratio classification, coefficient products, combination and rounding
// four handshaked stages; depends on alc_pkg
`timescale 1ns / 1ps

module alc_front
  import alc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [DIV_W-1:0]   divisor_i,
  input  logic               up_valid_i,
  output logic               up_ready_o,
  input  logic [CNT_W-1:0]   c0_i,
  input  logic [CNT_W-1:0]   c1_i,
  output logic               dn_valid_o,
  input  logic               dn_ready_i,
  output logic [Y_W-1:0]     y_o,
  output alc_region_e        region_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  logic [CNT_W-1:0] c0_1_q, c1_1_q;
  alc_region_e      reg_1_q, reg_2_q, reg_3_q, reg_4_q;
  logic [PROD_W-1:0] p0_q, p1_q;
  logic [SUM_W-1:0]  sum_q;
  logic [Y_W-1:0]    y_q;

  logic [CNT_W:0]   s_sum;
  logic [CMP_W-1:0] c1_x, s_t0, s_t1, s_t2;
  alc_region_e      reg_d;
  logic [COEF_W-1:0] ca, cb;
  logic [PROD_W-1:0] p0_d, p1_d;
  logic [SUM_W-1:0]  sum_d;
  logic [X_W-1:0]    x_d;

  assign r4 = !v4_q || dn_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign up_ready_o = r1;

  // ratio region by cross-multiplication
  always_comb begin
    s_sum = {1'b0, c0_i} + {1'b0, c1_i};
    c1_x  = CMP_W'(c1_i) * CMP_W'(RATIO_SCALE);
    s_t0  = CMP_W'(s_sum) * CMP_W'(RATIO_T0);
    s_t1  = CMP_W'(s_sum) * CMP_W'(RATIO_T1);
    s_t2  = CMP_W'(s_sum) * CMP_W'(RATIO_T2);
    if (s_sum == '0 || c1_x >= s_t2) begin
      reg_d = REG_OUT;
    end else if (c1_x < s_t0) begin
      reg_d = REG_LOW;
    end else if (c1_x < s_t1) begin
      reg_d = REG_MID;
    end else begin
      reg_d = REG_HIGH;
    end
  end

  always_comb begin
    case (reg_1_q)
      REG_LOW: begin
        ca = COEF_W'(CA_L);
        cb = COEF_W'(CB_L);
      end
      REG_MID: begin
        ca = COEF_W'(CA_M);
        cb = COEF_W'(CB_M);
      end
      REG_HIGH: begin
        ca = COEF_W'(CA_H);
        cb = COEF_W'(CB_H);
      end
      default: begin
        ca = '0;
        cb = '0;
      end
    endcase
    p0_d = PROD_W'(ca) * PROD_W'(c0_1_q);
    p1_d = PROD_W'(cb) * PROD_W'(c1_1_q);
  end

  // region mid subtracts, clamped at zero
  always_comb begin
    if (reg_2_q == REG_MID) begin
      sum_d = (p0_q > p1_q) ? SUM_W'(p0_q - p1_q) : '0;
    end else begin
      sum_d = SUM_W'(p0_q) + SUM_W'(p1_q);
    end
  end

  // half-divisor rounding term, then drop the coefficient fraction
  always_comb begin
    x_d = (X_W'(sum_q) << OUT_FRAC_BITS) + (X_W'(divisor_i) << (COEF_FRAC_BITS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= up_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && up_valid_i) begin
      c0_1_q  <= c0_i;
      c1_1_q  <= c1_i;
      reg_1_q <= reg_d;
    end
    if (r2 && v1_q) begin
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      reg_2_q <= reg_1_q;
    end
    if (r3 && v2_q) begin
      sum_q   <= sum_d;
      reg_3_q <= reg_2_q;
    end
    if (r4 && v3_q) begin
      y_q     <= x_d[X_W-1:COEF_FRAC_BITS];
      reg_4_q <= reg_3_q;
    end
  end

  assign dn_valid_o = v4_q;
  assign y_o        = y_q;
  assign region_o   = reg_4_q;

`ifndef SYNTH
  a_out_region_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && reg_3_q == REG_OUT) |-> (sum_q == '0))
    else $error("out-of-range region carries a nonzero sum");
`endif

endmodule

// File: design/alc_cell.sv
// alc_cell: one restoring division step, one quotient bit per cell
// handshaked register stage of the divider chain; depends on alc_pkg
`timescale 1ns / 1ps

module alc_cell
  import alc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIV_W-1:0] divisor_i,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  alc_cell_t        up_data_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output alc_cell_t        dn_data_o
);

  logic      v_q;
  alc_cell_t data_q, data_d;
  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           take;

  assign up_ready_o = !v_q || dn_ready_i;

  always_comb begin
    trial = {up_data_i.rem, up_data_i.num[Y_W-1]};
    diff  = trial - {1'b0, divisor_i};
    take  = trial >= {1'b0, divisor_i};
    data_d.region = up_data_i.region;
    data_d.num    = {up_data_i.num[Y_W-2:0], take};
    data_d.rem    = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (up_ready_o) begin
      v_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = v_q;
  assign dn_data_o  = data_q;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (data_q.rem < divisor_i))
    else $error("partial remainder not below divisor");
`endif

endmodule
